// File: hdl/dmq_pkg.sv
// ----------------------------------------------------------------------------
// dmq_pkg
// Shared types, event codes and register indexes of the deferred message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dmq_pkg;

    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_CHANNELS    = 2;

    localparam int KIND_W  = 4;
    localparam int FREE_W  = 12;
    localparam int LEN_W   = 8;
    localparam int OVH_W   = 5;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W = 3;

    // event codes carried on the result stream
    localparam logic [EVENT_W-1:0] EV_SENT_QUEUED = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SENT_NEW    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DEFERRED    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_DUPLICATE   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FULL        = 3'd4;
    localparam logic [EVENT_W-1:0] EV_RETRY_DONE  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_LEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS_RAW_LEN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LEN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_REQUEST_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_OVERHEAD     = 3'd4;

    // message kinds with a payload cost
    localparam logic [KIND_W-1:0] KIND_HEARTBEAT      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_GPS_RAW        = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POSITION       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_STREAM_REQUEST = 4'd3;

    // control word handed to every cell of one channel
    typedef struct packed {
        logic              pop;
        logic              push;
        logic [KIND_W-1:0] key;
    } t_cell_ctl;

    // payload cost of the kind under test
    typedef struct packed {
        logic             costed;
        logic [LEN_W-1:0] len;
        logic [OVH_W-1:0] overhead;
    } t_cost;

endpackage

`default_nettype wire

// File: hdl/deferred_message_queue_core.sv
// ----------------------------------------------------------------------------
// deferred_message_queue_core
// Per-channel deferred send queue with duplicate suppression.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: tuser = {channel, op},
//   tdata = {free_space, msg_kind}. m_axis returns the events of that request,
//   tuser = event code, tdata = kind, tlast on the final event.
//   The cfg channel writes payload lengths and frame overhead (always ready);
//   write it only while no request is in flight.
// Sequence:
//   One request at a time. The sequencer accepts a request and pops each
//   drained queue entry in turn; a retry then ends at the drain check, while
//   an offer runs through the drain check, match capture and decision.
//   The drain walk pops one head cell per cycle while the output register is free.
// Reset:
//   Synchronous active-low reset empties every queue and restores the default
//   lengths. Queue contents themselves are not cleared.
// Stall:
//   Results sit in a single output register; the sequencer holds while it is
//   full and m_axis_tready is low. A new request is taken while the final
//   result of the previous one still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_message_queue_core
    import dmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // msg_kind[3:0], free_space[15:4]
    input  wire logic [1:0]           s_axis_tuser,   // op[0], channel[1]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // kind[3:0], zero[7:4]
    output logic [EVENT_W-1:0]        m_axis_tuser,   // event_res[2:0]
    output logic                      m_axis_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DRAIN  = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]        r_state,  n_state;
    logic              r_op;
    logic [CH_W-1:0]   r_ch;
    logic [KIND_W-1:0] r_key;
    logic [FREE_W-1:0] r_free,   n_free;
    logic              r_m_valid, n_m_valid;
    logic [EVENT_W-1:0] r_m_event, n_m_event;
    logic [KIND_W-1:0] r_m_kind, n_m_kind;
    logic              r_m_last, n_m_last;

    logic [KIND_W-1:0]      w_kind  [CHANNELS][QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid [CHANNELS];
    logic [QUEUE_DEPTH-1:0] w_match [CHANNELS];
    t_cell_ctl              w_ctl   [CHANNELS];

    logic              w_slot_free;
    logic [KIND_W-1:0] w_head_kind;
    logic              w_head_valid;
    logic              w_empty;
    logic              w_full;
    logic              w_dup;
    logic [KIND_W-1:0] w_lookup_kind;
    t_cost             w_cost;
    logic              w_fits;
    logic [FREE_W-1:0] w_charge;
    logic              w_pop;
    logic              w_push;

    // ---- configuration and cost lookup ----
    dmq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (w_lookup_kind),
        .o_cost      (w_cost)
    );

    // ---- cell rows, one per channel ----
    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        assign w_ctl[c].pop  = w_pop  && (r_ch == CH_W'(c));
        assign w_ctl[c].push = w_push && (r_ch == CH_W'(c));
        assign w_ctl[c].key  = r_key;

        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            logic              w_prev_valid;
            logic [KIND_W-1:0] w_next_kind;
            logic              w_next_valid;

            if (i == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[c][i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_last
                assign w_next_kind  = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_inner
                assign w_next_kind  = w_kind[c][i+1];
                assign w_next_valid = w_valid[c][i+1];
            end

            dmq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[c]),
                .i_prev_valid (w_prev_valid),
                .i_next_kind  (w_next_kind),
                .i_next_valid (w_next_valid),
                .o_kind       (w_kind[c][i]),
                .o_valid      (w_valid[c][i]),
                .o_match      (w_match[c][i])
            );
        end
    end

    // ---- selected channel view ----
    assign w_head_kind  = w_kind[r_ch][0];
    assign w_head_valid = w_valid[r_ch][0];
    assign w_empty      = !w_valid[r_ch][0];
    assign w_full       = w_valid[r_ch][QUEUE_DEPTH-1];
    assign w_dup        = |w_match[r_ch];

    assign w_slot_free   = !r_m_valid || m_axis_tready;
    assign w_lookup_kind = (r_state == S_DRAIN) ? w_head_kind : r_key;
    assign w_fits        = !w_cost.costed || (r_free >= FREE_W'(w_cost.len));
    assign w_charge      = FREE_W'(w_cost.len) + FREE_W'(w_cost.overhead);

    assign w_pop  = (r_state == S_DRAIN) && w_slot_free && w_head_valid && w_fits;
    assign w_push = (r_state == S_DECIDE) && w_slot_free && !w_dup
                    && !(w_empty && w_fits) && !w_full;

    // ---- sequencer ----
    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_event = r_m_event;
        n_m_kind  = r_m_kind;
        n_m_last  = r_m_last;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DRAIN;
                    n_free  = s_axis_tdata[15:4];
                end
            end
            S_DRAIN: begin
                if (w_slot_free) begin
                    if (w_head_valid && w_fits) begin
                        // send the head and charge payload plus overhead
                        n_m_valid = 1'b1;
                        n_m_event = EV_SENT_QUEUED;
                        n_m_kind  = w_head_kind;
                        n_m_last  = 1'b0;
                        if (w_cost.costed) begin
                            n_free = (r_free > w_charge) ? r_free - w_charge : '0;
                        end
                    end else if (r_op) begin
                        n_m_valid = 1'b1;
                        n_m_event = EV_RETRY_DONE;
                        n_m_kind  = '0;
                        n_m_last  = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // cells capture their match bits in this cycle
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = r_key;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                    if (w_dup) begin
                        n_m_event = EV_DUPLICATE;
                    end else if (w_empty && w_fits) begin
                        n_m_event = EV_SENT_NEW;
                    end else if (w_full) begin
                        n_m_event = EV_FULL;
                    end else begin
                        n_m_event = EV_DEFERRED;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free    <= n_free;
        r_m_event <= n_m_event;
        r_m_kind  <= n_m_kind;
        r_m_last  <= n_m_last;
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= s_axis_tuser[0];
            r_ch  <= (CHANNELS > 1) ? CH_W'(s_axis_tuser[1]) : '0;
            r_key <= s_axis_tdata[3:0];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_m_kind};
    assign m_axis_tuser  = r_m_event;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

// File: hdl/dmq_cell.sv
// ----------------------------------------------------------------------------
// dmq_cell
// One queue slot: holds a deferred kind, shifts toward the head on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module dmq_cell
    import dmq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic              i_prev_valid,
    input  wire logic [KIND_W-1:0] i_next_kind,
    input  wire logic              i_next_valid,
    output logic [KIND_W-1:0]      o_kind,
    output logic                   o_valid,
    output logic                   o_match
);

    logic [KIND_W-1:0] r_kind;
    logic              r_valid;
    logic              r_match;

    // valid bits form a thermometer code: the first empty slot takes a push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_match <= r_valid && (r_kind == i_ctl.key);
            if (i_ctl.pop) begin
                r_valid <= i_next_valid;
            end else if (i_ctl.push && !r_valid && i_prev_valid) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_kind <= i_next_kind;
        end else if (i_ctl.push && !r_valid && i_prev_valid) begin
            r_kind <= i_ctl.key;
        end
    end

    assign o_kind  = r_kind;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

`default_nettype wire

// File: hdl/dmq_cfg.sv
// ----------------------------------------------------------------------------
// dmq_cfg
// Payload length and frame overhead registers with the per-kind cost lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module dmq_cfg
    import dmq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data,
    input  wire logic [KIND_W-1:0]    i_kind,
    output t_cost                     o_cost
);

    logic [LEN_W-1:0] r_heartbeat_len;
    logic [LEN_W-1:0] r_gps_raw_len;
    logic [LEN_W-1:0] r_position_len;
    logic [LEN_W-1:0] r_stream_request_len;
    logic [OVH_W-1:0] r_frame_overhead;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heartbeat_len      <= 8'd9;
            r_gps_raw_len        <= 8'd30;
            r_position_len       <= 8'd28;
            r_stream_request_len <= 8'd6;
            r_frame_overhead     <= 5'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEARTBEAT_LEN:      r_heartbeat_len      <= i_cfg_data;
                CFG_GPS_RAW_LEN:        r_gps_raw_len        <= i_cfg_data;
                CFG_POSITION_LEN:       r_position_len       <= i_cfg_data;
                CFG_STREAM_REQUEST_LEN: r_stream_request_len <= i_cfg_data;
                CFG_FRAME_OVERHEAD:     r_frame_overhead     <= i_cfg_data[OVH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cost.overhead = r_frame_overhead;
        o_cost.costed   = 1'b1;
        case (i_kind)
            KIND_HEARTBEAT:      o_cost.len = r_heartbeat_len;
            KIND_GPS_RAW:        o_cost.len = r_gps_raw_len;
            KIND_POSITION:       o_cost.len = r_position_len;
            KIND_STREAM_REQUEST: o_cost.len = r_stream_request_len;
            default: begin
                o_cost.len    = '0;
                o_cost.costed = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/dmq_checker.sv
// ----------------------------------------------------------------------------
// dmq_checker
// Port-level checks on the result stream of the deferred message queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dmq_checker
    import dmq_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [7:0]         m_axis_tdata,
    input wire logic [EVENT_W-1:0] m_axis_tuser,
    input wire logic               m_axis_tlast
);

    // a queue drain event never closes a transaction's result run
    a_drain_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_SENT_QUEUED) |-> !m_axis_tlast)
        else $error("drain event marked last");

    // every other event closes the run
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != EV_SENT_QUEUED) |-> m_axis_tlast)
        else $error("final event without tlast");

    // retry completion reports kind zero
    a_retry_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_RETRY_DONE) |-> (m_axis_tdata == 8'd0))
        else $error("retry done with nonzero kind");

    // one request at a time: input closes right after a transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind deferred_message_queue_core dmq_checker u_dmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: test/dmq_tb_pkg.sv
// ----------------------------------------------------------------------------
// dmq_tb_pkg
// Request operation codes shared by the queue testbench and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dmq_tb_pkg;

    // op bit carried in the low bit of the request tuser
    typedef enum logic {
        OP_OFFER = 1'b0,
        OP_RETRY = 1'b1
    } t_req_op;

endpackage

`default_nettype wire

// File: test/deferred_message_queue_checker.sv
// ----------------------------------------------------------------------------
// deferred_message_queue_checker
// Watches the request, event and register channels of the deferred message
// queue, keeps its own copy of the per-channel rings and register values,
// predicts the event sequence of every accepted request and compares each
// accepted event against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_message_queue_checker
    import dmq_pkg::*;
    import dmq_tb_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    input  wire logic                 i_req_ready,
    input  wire logic [15:0]          i_req_data,   // msg_kind[3:0], free_space[15:4]
    input  wire logic [1:0]           i_req_user,   // op[0], channel[1]
    input  wire logic                 i_evt_valid,
    input  wire logic                 i_evt_ready,
    input  wire logic [7:0]           i_evt_data,   // kind[3:0], zero[7:4]
    input  wire logic [EVENT_W-1:0]   i_evt_user,   // event_res[2:0]
    input  wire logic                 i_evt_last,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [EVENT_W-1:0] code;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } t_queue_event;

    t_queue_event      awaited_events[$];
    logic [LEN_W-1:0]  kind_len [4];
    logic [OVH_W-1:0]  overhead;
    logic [KIND_W-1:0] deferred [CHANNELS][QUEUE_DEPTH];
    int                ring_head [CHANNELS];
    int                ring_fill [CHANNELS];
    int                budget;
    int                err_count   = 0;
    int                event_count = 0;

    assign o_errors  = err_count;
    assign o_checked = event_count;

    task automatic push_event(input logic [EVENT_W-1:0] code, input logic [KIND_W-1:0] k,
                              input logic last);
        t_queue_event e;
        e.code = code;
        e.kind = k;
        e.last = last;
        awaited_events.push_back(e);
    endtask

    // send if it fits and charge payload plus frame bytes, floor at zero
    function automatic bit take_slot(input logic [KIND_W-1:0] k);
        int cost;
        if (k > KIND_STREAM_REQUEST)
            return 1'b1;
        if (budget < int'(kind_len[int'(k)]))
            return 1'b0;
        cost = int'(kind_len[int'(k)]) + int'(overhead);
        budget = (budget > cost) ? budget - cost : 0;
        return 1'b1;
    endfunction

    task automatic predict_events(input t_req_op op, input int ch_sel,
                                  input logic [KIND_W-1:0] k, input logic [FREE_W-1:0] fb);
        int  ch;
        int  pos;
        bit  dup;
        ch = ch_sel % CHANNELS;
        budget = int'(fb);
        dup = 1'b0;

        // drain the ring while the head fits
        while (ring_fill[ch] != 0) begin
            if (!take_slot(deferred[ch][ring_head[ch]]))
                break;
            push_event(EV_SENT_QUEUED, deferred[ch][ring_head[ch]], 1'b0);
            ring_head[ch] = (ring_head[ch] + 1) % QUEUE_DEPTH;
            ring_fill[ch]--;
        end

        if (op == OP_RETRY) begin
            push_event(EV_RETRY_DONE, '0, 1'b1);
        end else begin
            pos = ring_head[ch];
            for (int i = 0; i < ring_fill[ch]; i++) begin
                if (deferred[ch][pos] == k)
                    dup = 1'b1;
                pos = (pos + 1) % QUEUE_DEPTH;
            end
            if (dup) begin
                push_event(EV_DUPLICATE, k, 1'b1);
            end else if (ring_fill[ch] == 0 && take_slot(k)) begin
                push_event(EV_SENT_NEW, k, 1'b1);
            end else if (ring_fill[ch] >= QUEUE_DEPTH) begin
                push_event(EV_FULL, k, 1'b1);
            end else begin
                deferred[ch][(ring_head[ch] + ring_fill[ch]) % QUEUE_DEPTH] = k;
                ring_fill[ch]++;
                push_event(EV_DEFERRED, k, 1'b1);
            end
        end
    endtask

    task automatic flag_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: event mismatch: %s", $time, what);
    endtask

    task automatic check_event();
        t_queue_event want;
        if (awaited_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected event code %0d data 0x%02h last %0b",
                                    i_evt_user, i_evt_data, i_evt_last));
        end else begin
            want = awaited_events.pop_front();
            if (i_evt_user != want.code || i_evt_data != {4'b0, want.kind}
                    || i_evt_last != want.last)
                flag_mismatch($sformatf(
                    "expected code %0d kind %0d last %0b, got code %0d data 0x%02h last %0b",
                    want.code, want.kind, want.last, i_evt_user, i_evt_data, i_evt_last));
        end
        event_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kind_len[int'(KIND_HEARTBEAT)]      = 8'd9;
            kind_len[int'(KIND_GPS_RAW)]        = 8'd30;
            kind_len[int'(KIND_POSITION)]       = 8'd28;
            kind_len[int'(KIND_STREAM_REQUEST)] = 8'd6;
            overhead = 5'd8;
            for (int c = 0; c < CHANNELS; c++) begin
                ring_head[c] = 0;
                ring_fill[c] = 0;
            end
            awaited_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEARTBEAT_LEN:      kind_len[int'(KIND_HEARTBEAT)] = i_cfg_data;
                    CFG_GPS_RAW_LEN:        kind_len[int'(KIND_GPS_RAW)] = i_cfg_data;
                    CFG_POSITION_LEN:       kind_len[int'(KIND_POSITION)] = i_cfg_data;
                    CFG_STREAM_REQUEST_LEN: kind_len[int'(KIND_STREAM_REQUEST)] = i_cfg_data;
                    CFG_FRAME_OVERHEAD:     overhead = i_cfg_data[OVH_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                predict_events(t_req_op'(i_req_user[0]), int'(i_req_user[1]),
                               i_req_data[KIND_W-1:0], i_req_data[15:KIND_W]);
            if (i_evt_valid && i_evt_ready)
                check_event();
        end
        o_pending <= awaited_events.size();
    end

endmodule

`default_nettype wire

// File: test/deferred_message_queue_core_tb.sv
// ----------------------------------------------------------------------------
// deferred_message_queue_core_tb
// Drives requests and register writes into the deferred message queue with
// random idle cycles on both streams. A directed opening walks deferral,
// duplicates, exact fit, saturation, overflow and a full drain; random
// requests then run under several register settings. The checker beside the
// block predicts and compares every event.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_message_queue_core_tb;
    import dmq_pkg::*;
    import dmq_tb_pkg::*;

    localparam int IDLE_PCT        = 17;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = DEF_QUEUE_DEPTH + 8;
    localparam int ITEMS_PER_PHASE = 13;
    localparam int PHASES          = 6;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;   // msg_kind[3:0], free_space[15:4]
    logic [1:0]           s_axis_tuser  = '0;   // op[0], channel[1]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // kind[3:0], zero[7:4]
    logic [EVENT_W-1:0]   m_axis_tuser;         // event_res[2:0]
    logic                 m_axis_tlast;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_HEARTBEAT_LEN;
    logic [LEN_W-1:0]     i_cfg_data    = '0;

    int fail_count;
    int pending_events;
    int events_checked;
    int requests_sent  = 0;
    int settings_used  = 1;
    int cycle_count    = 0;
    bit steady         = 1'b0;

    deferred_message_queue_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    deferred_message_queue_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_evt_valid (m_axis_tvalid),
        .i_evt_ready (m_axis_tready),
        .i_evt_data  (m_axis_tdata),
        .i_evt_user  (m_axis_tuser),
        .i_evt_last  (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending_events),
        .o_checked   (events_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // event sink backpressure
    always @(posedge i_clk) begin
        if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_events != 0);
    endtask

    // keep tvalid high across back-to-back transactions; drop it only for a gap
    task automatic send_request(input t_req_op op, input logic ch,
                                input logic [KIND_W-1:0] k, input logic [FREE_W-1:0] fb);
        int gap;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fb, k};
        s_axis_tuser  <= {ch, op};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic program_registers(input logic [LEN_W-1:0] hb_len,
                                     input logic [LEN_W-1:0] gps_len,
                                     input logic [LEN_W-1:0] pos_len,
                                     input logic [LEN_W-1:0] sreq_len,
                                     input logic [OVH_W-1:0] ovh);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [LEN_W-1:0]     val [5];
        idx = '{CFG_HEARTBEAT_LEN, CFG_GPS_RAW_LEN, CFG_POSITION_LEN,
                CFG_STREAM_REQUEST_LEN, CFG_FRAME_OVERHEAD};
        val = '{hb_len, gps_len, pos_len, sreq_len, LEN_W'(ovh)};
        s_axis_tvalid <= 1'b0;
        wait_drained();
        for (int r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data  <= val[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_request();
        t_req_op           op;
        logic              ch;
        logic [KIND_W-1:0] k;
        logic [FREE_W-1:0] fb;
        op = ($urandom_range(0, 99) < 15) ? OP_RETRY : OP_OFFER;
        ch = 1'($urandom_range(0, 1));
        // favor the costed kinds so the rings fill and drain
        if ($urandom_range(0, 1) != 0)
            k = KIND_W'($urandom_range(0, 3));
        else
            k = KIND_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: fb = FREE_W'($urandom_range(0, 63));
            4, 5:       fb = FREE_W'($urandom_range(0, 511));
            8:          fb = '0;
            9:          fb = '1;
            default:    fb = FREE_W'($urandom);
        endcase
        send_request(op, ch, k, fb);
    endtask

    initial begin
        logic [KIND_W-1:0] fill_kinds [8];
        fill_kinds = '{KIND_GPS_RAW, KIND_POSITION, KIND_STREAM_REQUEST, KIND_HEARTBEAT,
                       4'd4, 4'd6, 4'd7, 4'd8};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // channel 0: defer, duplicate, free kind queued behind, retry drain
        send_request(OP_OFFER, 1'b0, KIND_HEARTBEAT, '0);
        send_request(OP_OFFER, 1'b0, KIND_HEARTBEAT, '0);
        send_request(OP_OFFER, 1'b0, 4'd5, '0);
        send_request(OP_RETRY, 1'b0, 4'd10, '1);
        // exact fit then saturation to zero, fit one short of length
        send_request(OP_OFFER, 1'b0, KIND_GPS_RAW, 12'd30);
        send_request(OP_OFFER, 1'b0, KIND_GPS_RAW, 12'd29);
        send_request(OP_OFFER, 1'b0, KIND_STREAM_REQUEST, '0);
        // drain stops at the first head that no longer fits
        send_request(OP_RETRY, 1'b0, KIND_HEARTBEAT, 12'd31);
        send_request(OP_OFFER, 1'b0, KIND_STREAM_REQUEST, 12'd6);

        // channel 1: free kind sent at once, ring filled to overflow, full drain
        send_request(OP_OFFER, 1'b1, 4'd15, '1);
        foreach (fill_kinds[i])
            send_request(OP_OFFER, 1'b1, fill_kinds[i], '0);
        send_request(OP_OFFER, 1'b1, 4'd9, '0);
        send_request(OP_OFFER, 1'b1, KIND_POSITION, '0);
        send_request(OP_RETRY, 1'b1, 4'd15, '1);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: program_registers('0, '0, '0, '0, '0);
                2: program_registers('1, '1, '1, '1, '1);
                3: program_registers(LEN_W'($urandom_range(0, 63)),
                                     LEN_W'($urandom_range(0, 63)),
                                     LEN_W'($urandom_range(0, 63)),
                                     LEN_W'($urandom_range(0, 63)),
                                     OVH_W'($urandom_range(0, 31)));
                4: program_registers(LEN_W'($urandom), LEN_W'($urandom),
                                     LEN_W'($urandom), LEN_W'($urandom),
                                     OVH_W'($urandom));
                5: program_registers(8'd9, 8'd30, 8'd28, 8'd6, 5'd8);
                default: ;
            endcase
            steady = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // hold the sender until every event is back
                if (p == 3 && n == ITEMS_PER_PHASE / 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                random_request();
            end
        end

        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests on both channels under %0d register settings,",
                 requests_sent, settings_used);
        $display("with %0d events checked across deferral, duplicates, overflow and drains.",
                 events_checked);
        if (fail_count == 0 && pending_events == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/dmq_pkg.sv
hdl/dmq_cell.sv
hdl/dmq_cfg.sv
hdl/deferred_message_queue_core.sv
hdl/dmq_checker.sv
test/dmq_tb_pkg.sv
test/deferred_message_queue_checker.sv
test/deferred_message_queue_core_tb.sv
